/* hdl/dsu_pkg.sv */
// shared types and constants for the union-find engine
// field widths, controller states, command and status words
// no dependencies
package dsu_pkg;

    // widths of the channel fields
    localparam int NODE_W    = 10;
    localparam int ROOT_W    = 10;
    localparam int COUNT_W   = 11;
    // number of distinct values a node field can carry
    localparam int NODE_SPAN = 1 << NODE_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_A_ISSUE,
        ST_A_CHECK,
        ST_B_ISSUE,
        ST_B_CHECK,
        ST_SZ_A,
        ST_SZ_B,
        ST_LINK
    } dsu_state_t;

    // parent store read address source
    typedef enum logic [1:0] {
        PSEL_REM_A,
        PSEL_REM_B,
        PSEL_NEXT
    } par_sel_t;

    // size store read address source
    typedef enum logic {
        SSEL_ROOT_A,
        SSEL_ROOT_B
    } size_sel_t;

    typedef struct packed {
        logic      req_ready;
        logic      load;
        logic      clear_en;
        logic      reduce_step;
        logic      par_re;
        par_sel_t  par_sel;
        logic      load_cur_a;
        logic      load_cur_b;
        logic      size_re;
        size_sel_t size_sel;
        logic      cap_size_a;
        logic      link;
    } dsu_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic reduce_done;
        logic a_at_root;
        logic b_at_root;
        logic out_free;
    } dsu_status_t;

endpackage

/* hdl/dsu_req_if.sv */
// request channel: valid, ready and the two node numbers
// depends on dsu_pkg
interface dsu_req_if import dsu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output node_a, output node_b, input ready);
    modport sink   (input valid, input node_a, input node_b, output ready);

endinterface

/* hdl/dsu_rsp_if.sv */
// response channel: valid, ready and the merge result
// depends on dsu_pkg
interface dsu_rsp_if import dsu_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               merged;
    logic [ROOT_W-1:0]  group_root;
    logic [COUNT_W-1:0] group_count;

    modport source (output valid, output merged, output group_root,
                    output group_count, input ready);
    modport sink   (input valid, input merged, input group_root,
                    input group_count, output ready);

endinterface

/* hdl/dsu_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/dsu_ctrl.sv */
// controller state machine for the union-find engine
// depends on dsu_pkg; drives dsu_datapath through the command word
module dsu_ctrl import dsu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  dsu_status_t st,
    output dsu_cmd_t    cmd
);

    dsu_state_t state_reg;
    dsu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (st.reduce_done)
                begin
                    state_next = ST_A_ISSUE;
                end
            end
            ST_A_ISSUE: state_next = ST_A_CHECK;
            ST_A_CHECK:
            begin
                if (st.a_at_root)
                begin
                    state_next = ST_B_ISSUE;
                end
            end
            ST_B_ISSUE: state_next = ST_B_CHECK;
            ST_B_CHECK:
            begin
                if (st.b_at_root)
                begin
                    state_next = ST_SZ_A;
                end
            end
            ST_SZ_A:    state_next = ST_SZ_B;
            ST_SZ_B:    state_next = ST_LINK;
            ST_LINK:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.par_sel  = PSEL_NEXT;
        cmd.size_sel = SSEL_ROOT_A;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.req_ready = 1'b1;
                cmd.load      = req_valid;
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
            end
            ST_A_ISSUE:
            begin
                cmd.par_re     = 1'b1;
                cmd.par_sel    = PSEL_REM_A;
                cmd.load_cur_a = 1'b1;
            end
            ST_A_CHECK:
            begin
                // not yet at the root: follow the link just read
                cmd.par_re     = !st.a_at_root;
                cmd.par_sel    = PSEL_NEXT;
                cmd.load_cur_a = !st.a_at_root;
            end
            ST_B_ISSUE:
            begin
                cmd.par_re     = 1'b1;
                cmd.par_sel    = PSEL_REM_B;
                cmd.load_cur_b = 1'b1;
            end
            ST_B_CHECK:
            begin
                cmd.par_re     = !st.b_at_root;
                cmd.par_sel    = PSEL_NEXT;
                cmd.load_cur_b = !st.b_at_root;
            end
            ST_SZ_A:
            begin
                cmd.size_re  = 1'b1;
                cmd.size_sel = SSEL_ROOT_A;
            end
            ST_SZ_B:
            begin
                cmd.size_re    = 1'b1;
                cmd.size_sel   = SSEL_ROOT_B;
                cmd.cap_size_a = 1'b1;
            end
            ST_LINK:
            begin
                cmd.link = st.out_free;
            end
            default:
            begin
                cmd.clear_en = 1'b0;
            end
        endcase
    end

    // a link must never fire while the output word is still held
    a_link_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> st.out_free)
        else $error("link issued while output word occupied");

    // the clear sweep only ends once its last entry is reached
    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && state_next != ST_CLEAR) |-> st.clear_done)
        else $error("clear sweep left early");

    // the first walk only hands over once it sits on a root
    a_walk_a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_CHECK && state_next == ST_B_ISSUE) |-> st.a_at_root)
        else $error("first walk left before its root");

endmodule

/* hdl/dsu_datapath.sv */
// datapath of the union-find engine: node reduction, root walks,
// parent and size stores, link update and output word register
// depends on dsu_pkg and dsu_ram
module dsu_datapath import dsu_pkg::*; #(
    parameter int NODE_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dsu_cmd_t           cmd,
    output dsu_status_t        st,
    input  logic [NODE_W-1:0]  node_a,
    input  logic [NODE_W-1:0]  node_b,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic               rsp_merged,
    output logic [ROOT_W-1:0]  rsp_group_root,
    output logic [COUNT_W-1:0] rsp_group_count
);

    localparam int NW        = $clog2(NODE_COUNT);
    localparam int SZW       = $clog2(NODE_COUNT + 1);
    localparam int MOD_STEPS = (NODE_COUNT >= NODE_SPAN) ? 1
                             : $clog2(NODE_SPAN / NODE_COUNT + 1);
    localparam int RCW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int SW        = $clog2(NODE_COUNT + 1) + MOD_STEPS - 1;
    localparam logic [SW-1:0]  SUB_INIT = SW'(NODE_COUNT) << (MOD_STEPS - 1);
    localparam logic [RCW-1:0] RED_LAST = RCW'(MOD_STEPS - 1);
    localparam logic [NW-1:0]  CLR_LAST = NW'(NODE_COUNT - 1);

    logic [NODE_W-1:0]  rem_a_reg, rem_a_next;
    logic [NODE_W-1:0]  rem_b_reg, rem_b_next;
    logic [SW-1:0]      sub_reg, sub_next;
    logic [RCW-1:0]     red_cnt_reg, red_cnt_next;
    logic [NW-1:0]      cur_a_reg, cur_a_next;
    logic [NW-1:0]      cur_b_reg, cur_b_next;
    logic [SZW-1:0]     size_a_reg, size_a_next;
    logic [NW-1:0]      clr_idx_reg, clr_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               merged_reg, merged_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic           par_we;
    logic [NW-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
    logic           size_we;
    logic [NW-1:0]  size_waddr, size_raddr;
    logic [SZW-1:0] size_wdata, size_rdata;

    logic           same_root;
    logic           a_wins;
    logic [NW-1:0]  winner, loser;
    logic [SZW-1:0] size_sum;
    logic [SZW-1:0] size_out;

    // link decision; size_rdata still holds the size of root b
    assign same_root = (cur_a_reg == cur_b_reg);
    assign a_wins    = (size_a_reg > size_rdata);
    assign winner    = a_wins ? cur_a_reg : cur_b_reg;
    assign loser     = a_wins ? cur_b_reg : cur_a_reg;
    assign size_sum  = size_a_reg + size_rdata;
    assign size_out  = same_root ? size_a_reg : size_sum;

    always_comb
    begin
        case (cmd.par_sel)
            PSEL_REM_A: par_raddr = NW'(rem_a_reg);
            PSEL_REM_B: par_raddr = NW'(rem_b_reg);
            PSEL_NEXT:  par_raddr = par_rdata;
            default:    par_raddr = par_rdata;
        endcase
    end

    assign size_raddr = (cmd.size_sel == SSEL_ROOT_B) ? cur_b_reg : cur_a_reg;

    // store writes: reset sweep or the link of two roots
    assign par_we     = cmd.clear_en || (cmd.link && !same_root);
    assign par_waddr  = cmd.clear_en ? clr_idx_reg : loser;
    assign par_wdata  = cmd.clear_en ? clr_idx_reg : winner;
    assign size_we    = par_we;
    assign size_waddr = cmd.clear_en ? clr_idx_reg : winner;
    assign size_wdata = cmd.clear_en ? SZW'(1) : size_sum;

    dsu_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (cmd.par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    dsu_ram #(.WIDTH(SZW), .DEPTH(NODE_COUNT)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .re    (cmd.size_re),
        .raddr (size_raddr),
        .rdata (size_rdata)
    );

    always_comb
    begin
        rem_a_next     = rem_a_reg;
        rem_b_next     = rem_b_reg;
        sub_next       = sub_reg;
        red_cnt_next   = red_cnt_reg;
        cur_a_next     = cur_a_reg;
        cur_b_next     = cur_b_reg;
        size_a_next    = size_a_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        merged_next    = merged_reg;
        root_next      = root_reg;
        count_next     = count_reg;

        if (cmd.clear_en)
        begin
            clr_idx_next = clr_idx_reg + NW'(1);
        end
        if (cmd.load)
        begin
            rem_a_next   = node_a;
            rem_b_next   = node_b;
            sub_next     = SUB_INIT;
            red_cnt_next = RED_LAST;
        end
        // restoring reduction modulo the node count, one shifted divisor a cycle
        if (cmd.reduce_step)
        begin
            if (SW'(rem_a_reg) >= sub_reg)
            begin
                rem_a_next = rem_a_reg - NODE_W'(sub_reg);
            end
            if (SW'(rem_b_reg) >= sub_reg)
            begin
                rem_b_next = rem_b_reg - NODE_W'(sub_reg);
            end
            sub_next     = sub_reg >> 1;
            red_cnt_next = red_cnt_reg - RCW'(1);
        end
        if (cmd.load_cur_a)
        begin
            cur_a_next = par_raddr;
        end
        if (cmd.load_cur_b)
        begin
            cur_b_next = par_raddr;
        end
        if (cmd.cap_size_a)
        begin
            size_a_next = size_rdata;
        end
        if (cmd.link)
        begin
            out_valid_next = 1'b1;
            merged_next    = !same_root;
            root_next      = ROOT_W'(winner);
            count_next     = COUNT_W'(size_out);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_a_reg   <= rem_a_next;
        rem_b_reg   <= rem_b_next;
        sub_reg     <= sub_next;
        red_cnt_reg <= red_cnt_next;
        cur_a_reg   <= cur_a_next;
        cur_b_reg   <= cur_b_next;
        size_a_reg  <= size_a_next;
        merged_reg  <= merged_next;
        root_reg    <= root_next;
        count_reg   <= count_next;
    end

    assign st.clear_done  = (clr_idx_reg == CLR_LAST);
    assign st.reduce_done = (red_cnt_reg == '0);
    assign st.a_at_root   = (par_rdata == cur_a_reg);
    assign st.b_at_root   = (par_rdata == cur_b_reg);
    assign st.out_free    = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_merged      = merged_reg;
    assign rsp_group_root  = root_reg;
    assign rsp_group_count = count_reg;

    // a link never points a root at itself
    a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.link && !same_root) |-> (par_waddr != par_wdata))
        else $error("root linked under itself");

    // a new output word only appears right after a link
    a_word_from_link: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.link))
        else $error("output word without a link");

    // joined size always grows past the first group
    a_size_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.link && !same_root) |-> (size_sum > size_a_reg))
        else $error("group size did not grow on merge");

endmodule

/* hdl/disjoint_set_union_by_size.sv */
// top level of the union-find engine (union by size, no path compression)
// depends on dsu_pkg, dsu_req_if, dsu_rsp_if, dsu_ctrl, dsu_datapath
//
// usage
//   req carries one union request per word: node_a and node_b; a node
//   number at or above NODE_COUNT is reduced modulo NODE_COUNT first
//   rsp returns exactly one word per request: merged, group_root and
//   group_count (root and size of the group now holding both nodes)
//   both channels move a word at a clock edge with valid and ready high
// request flow
//   one request at a time; an accepted request goes through the modulo
//   reduction (1 step when NODE_COUNT is 1024 or more), a walk from
//   each node up its links to its root (at most log2 of NODE_COUNT
//   links under union by size), the two size reads and the link; the
//   next request is taken in the cycle after the link; the two walks
//   take turns on the single read port of the parent ram
// reset
//   rst_n low clears the controller; afterwards a sweep over all
//   NODE_COUNT entries writes the identity into the parent ram and one
//   into every size entry, and req.ready stays low until it ends
// stalls
//   a finished word sits in the output register while rsp.ready is low;
//   the next request is accepted and walked meanwhile, and its link waits
//   until the output register is free
module disjoint_set_union_by_size import dsu_pkg::*; #(
    parameter int NODE_COUNT = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    dsu_req_if.sink   req,
    dsu_rsp_if.source rsp
);

    dsu_cmd_t    cmd;
    dsu_status_t st;

    // sequencing of the reduction, both walks and the link
    dsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .st        (st),
        .cmd       (cmd)
    );

    assign req.ready = cmd.req_ready;

    // stores, walk registers and the output word
    dsu_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .node_a          (req.node_a),
        .node_b          (req.node_b),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_merged      (rsp.merged),
        .rsp_group_root  (rsp.group_root),
        .rsp_group_count (rsp.group_count)
    );

    // a request is only taken when the controller is ready and it is offered
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (req.valid && req.ready))
        else $error("request loaded without handshake");

    // a held output word is not replaced before it is taken
    a_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.group_root)))
        else $error("held output word lost");

    // no request is taken while a link is being issued
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> !req.ready)
        else $error("request accepted during link");

endmodule
